### rtl/rtc_enc_pkg.sv
// package: types, tables and helper functions of the rtc time register encoder
`timescale 1ns / 1ps
package rtc_enc_pkg;

	localparam logic [11:0] YearBase = 12'd2000;
	localparam logic [11:0] YearTop  = 12'd2099;
	localparam logic [6:0]  SecMax   = 7'd59;
	localparam logic [6:0]  HourMax  = 7'd23;
	localparam logic [6:0]  MonthMax = 7'd12;
	localparam logic [6:0]  DateMax  = 7'd31;
	localparam logic [3:0]  MonthFeb = 4'd2;
	localparam logic [8:0]  WeekOfs  = 9'd4;

	// clamped fields after the first stage
	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [3:0] month;
		logic [4:0] date;
		logic [6:0] yoff;
	} clamp_t;

	// bcd fields plus what the weekday count still needs
	typedef struct packed {
		logic [6:0] sec_bcd;
		logic [6:0] min_bcd;
		logic [5:0] hour_bcd;
		logic [4:0] month_bcd;
		logic [7:0] year_bcd;
		logic [4:0] date;
		logic       leap;
		logic [8:0] cum;
		logic [6:0] yoff;
	} conv_t;

	// all bcd fields plus the raw weekday count
	typedef struct packed {
		logic [6:0] sec_bcd;
		logic [6:0] min_bcd;
		logic [5:0] hour_bcd;
		logic [5:0] date_bcd;
		logic [4:0] month_bcd;
		logic [7:0] year_bcd;
		logic [8:0] days;
	} sum_t;

	// clamp a signed byte to 0..hi
	function automatic logic [6:0] clamp_s8(input logic signed [7:0] v, input logic [6:0] hi);
		logic [6:0] r;
		if (v[7]) begin
			r = 7'd0;
		end else if (v[6:0] > hi) begin
			r = hi;
		end else begin
			r = v[6:0];
		end
		return r;
	endfunction

	// month length, february fixed at 28
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] r;
		unique case (m)
			4'd2:                      r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
			default:                   r = 5'd31;
		endcase
		return r;
	endfunction

	// days before the first of month m
	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] r;
		unique case (m)
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// packed bcd of 0..99, tens by reciprocal multiply
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [13:0] p;
		logic [3:0]  q;
		logic [6:0]  r;
		p = 14'(v) * 14'd103;
		q = p[13:10];
		r = v - 7'(q) * 7'd10;
		return {q, r[3:0]};
	endfunction

	// remainder by seven, using 8 = 1 mod 7
	function automatic logic [2:0] mod7(input logic [8:0] x);
		logic [6:0] s;
		logic [3:0] t;
		logic [3:0] r;
		s = 7'(x[8:3]) + 7'(x[2:0]);
		t = 4'(s[6:3]) + 4'(s[2:0]);
		if (t >= 4'd14) begin
			r = t - 4'd14;
		end else if (t >= 4'd7) begin
			r = t - 4'd7;
		end else begin
			r = t;
		end
		return r[2:0];
	endfunction

endpackage

### rtl/rtc_time_register_encoder_top.sv
// top level: rtc time register encoder, four stage pipeline
`timescale 1ns / 1ps
// rtc time register encoder
// input channel: in_valid / in_ready with sec_in, min_in, hour_in, date_in,
//   month_in (signed bytes) and year_in (12-bit full year)
// output channel: out_valid / out_ready with the seven rtc register bytes
//   sec_bcd, min_bcd, hour_bcd, weekday, date_bcd, month_bcd, year_bcd
// each accepted beat gives exactly one result beat, in order
// stages:
//   s1 clamps every field, year becomes an offset from 2000
//   s2 clamps the date to the month length, looks up the cumulative
//      month days, converts sec/min/hour/month/year to bcd
//   s3 converts the date and adds up the weekday count
//   s4 takes the count mod 7 and is the output register
// out_valid is the s4 valid bit; an accepted beat passes s1, s2, s3 and s4
//   in order, and waits in its stage while the receiver stalls
// throughput is one beat per cycle while out_ready is high; a stage moves
//   on when it is empty or the one after it moves, so a stalled receiver
//   fills the pipe and then drops in_ready, and nothing is lost or repeated
// reset clears all stage valid bits; in_ready is high right after reset
module rtc_time_register_encoder_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [7:0] sec_in,
	input  logic signed [7:0] min_in,
	input  logic signed [7:0] hour_in,
	input  logic signed [7:0] date_in,
	input  logic signed [7:0] month_in,
	input  logic [11:0]       year_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [6:0]        sec_bcd,
	output logic [6:0]        min_bcd,
	output logic [5:0]        hour_bcd,
	output logic [2:0]        weekday,
	output logic [5:0]        date_bcd,
	output logic [4:0]        month_bcd,
	output logic [7:0]        year_bcd
);
	import rtc_enc_pkg::*;

	logic   v_s1, v_s2, v_s3, v_s4;
	logic   en1, en2, en3, en4;
	clamp_t d_s1, c1;
	conv_t  d_s2, c2;
	sum_t   d_s3, c3;
	logic [2:0] wd_s4;
	logic [6:0] sec_bcd_s4, min_bcd_s4;
	logic [5:0] hour_bcd_s4, date_bcd_s4;
	logic [4:0] month_bcd_s4;
	logic [7:0] year_bcd_s4;

	// a stage loads when it is empty or its contents move on
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	// stage 1: clamp fields
	always_comb begin
		logic [6:0] m;
		c1.sec   = 6'(clamp_s8(sec_in, SecMax));
		c1.min   = 6'(clamp_s8(min_in, SecMax));
		c1.hour  = 5'(clamp_s8(hour_in, HourMax));
		m        = clamp_s8(month_in, MonthMax);
		c1.month = (m == 7'd0) ? 4'd1 : m[3:0];
		c1.date  = 5'(clamp_s8(date_in, DateMax));
		if (year_in < YearBase) begin
			c1.yoff = 7'd0;
		end else if (year_in > YearTop) begin
			c1.yoff = 7'(YearTop - YearBase);
		end else begin
			c1.yoff = 7'(year_in - YearBase);
		end
	end

	// stage 2: month length clamp, table lookup, bcd of the simple fields
	always_comb begin
		logic [4:0] len;
		len          = month_len(d_s1.month);
		c2.date      = (d_s1.date > len) ? len : d_s1.date;
		c2.sec_bcd   = 7'(to_bcd(7'(d_s1.sec)));
		c2.min_bcd   = 7'(to_bcd(7'(d_s1.min)));
		c2.hour_bcd  = 6'(to_bcd(7'(d_s1.hour)));
		c2.month_bcd = 5'(to_bcd(7'(d_s1.month)));
		c2.year_bcd  = to_bcd(d_s1.yoff);
		c2.leap      = (d_s1.month > MonthFeb) && (d_s1.yoff[1:0] == 2'd0);
		c2.cum       = cum_days(d_s1.month);
		c2.yoff      = d_s1.yoff;
	end

	// stage 3: date bcd and weekday count (365 = 1 mod 7, so y stands for 365y)
	always_comb begin
		logic [7:0] yq;
		yq           = 8'(d_s2.yoff) + 8'd3;
		c3.sec_bcd   = d_s2.sec_bcd;
		c3.min_bcd   = d_s2.min_bcd;
		c3.hour_bcd  = d_s2.hour_bcd;
		c3.date_bcd  = 6'(to_bcd(7'(d_s2.date)));
		c3.month_bcd = d_s2.month_bcd;
		c3.year_bcd  = d_s2.year_bcd;
		c3.days      = 9'(d_s2.date) + d_s2.cum + 9'(d_s2.leap) + 9'(d_s2.yoff)
			+ 9'(yq[7:2]) + WeekOfs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (en1 && in_valid) d_s1 <= c1;
		if (en2 && v_s1)     d_s2 <= c2;
		if (en3 && v_s2)     d_s3 <= c3;
		if (en4 && v_s3) begin
			sec_bcd_s4   <= d_s3.sec_bcd;
			min_bcd_s4   <= d_s3.min_bcd;
			hour_bcd_s4  <= d_s3.hour_bcd;
			date_bcd_s4  <= d_s3.date_bcd;
			month_bcd_s4 <= d_s3.month_bcd;
			year_bcd_s4  <= d_s3.year_bcd;
			wd_s4        <= mod7(d_s3.days) + 3'd1;
		end
	end

	assign out_valid = v_s4;
	assign sec_bcd   = sec_bcd_s4;
	assign min_bcd   = min_bcd_s4;
	assign hour_bcd  = hour_bcd_s4;
	assign weekday   = wd_s4;
	assign date_bcd  = date_bcd_s4;
	assign month_bcd = month_bcd_s4;
	assign year_bcd  = year_bcd_s4;

endmodule

### rtl/rtc_enc_checker.sv
// checker: port-level assertions for the rtc time register encoder, with bind
`timescale 1ns / 1ps
module rtc_enc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] sec_bcd,
	input logic [6:0] min_bcd,
	input logic [5:0] hour_bcd,
	input logic [2:0] weekday,
	input logic [5:0] date_bcd,
	input logic [4:0] month_bcd,
	input logic [7:0] year_bcd
);

	// stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped under stall");

	// stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({sec_bcd, min_bcd, hour_bcd, weekday,
			date_bcd, month_bcd, year_bcd}))
		else $error("result payload changed under stall");

	// weekday never zero
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weekday != 3'd0)
		else $error("weekday out of range");

	// clamped fields are legal bcd
	a_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sec_bcd[3:0] <= 4'd9 && sec_bcd[6:4] <= 3'd5
			&& min_bcd[3:0] <= 4'd9 && min_bcd[6:4] <= 3'd5
			&& hour_bcd[3:0] <= 4'd9 && month_bcd != 5'd0
			&& year_bcd[3:0] <= 4'd9 && year_bcd[7:4] <= 4'd9)
		else $error("result field is not a legal bcd value");

endmodule

bind rtc_time_register_encoder_top rtc_enc_checker u_rtc_enc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sec_bcd   (sec_bcd),
	.min_bcd   (min_bcd),
	.hour_bcd  (hour_bcd),
	.weekday   (weekday),
	.date_bcd  (date_bcd),
	.month_bcd (month_bcd),
	.year_bcd  (year_bcd)
);

### sim/tb_rtc_time_register_encoder_top.sv
// testbench: rtc time register encoder, randomized handshakes with a field-by-field scoreboard
`timescale 1ns / 1ps
module tb_rtc_time_register_encoder_top;

	// one requested calendar time as it goes into the block
	typedef struct packed {
		logic signed [7:0] sec;
		logic signed [7:0] min;
		logic signed [7:0] hour;
		logic signed [7:0] date;
		logic signed [7:0] month;
		logic [11:0]       year;
	} time_req_t;

	// the seven register bytes the block should hand back
	typedef struct packed {
		logic [6:0] sec_bcd;
		logic [6:0] min_bcd;
		logic [5:0] hour_bcd;
		logic [2:0] weekday;
		logic [5:0] date_bcd;
		logic [4:0] month_bcd;
		logic [7:0] year_bcd;
	} rtc_regs_t;

	localparam int RandomBeats = 1480;
	localparam int HoldAtResult = 1000;   // result count that starts the long receiver hold
	localparam int HoldCycles = 60;
	localparam int CalmFrom = 500;        // accepted beats between these see no idling at all
	localparam int CalmTo = 800;
	localparam int DrainCycles = 10;      // pipe is four deep, a little slack on top

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic signed [7:0] sec_in = '0;
	logic signed [7:0] min_in = '0;
	logic signed [7:0] hour_in = '0;
	logic signed [7:0] date_in = '0;
	logic signed [7:0] month_in = '0;
	logic [11:0]       year_in = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [6:0]        sec_bcd;
	logic [6:0]        min_bcd;
	logic [5:0]        hour_bcd;
	logic [2:0]        weekday;
	logic [5:0]        date_bcd;
	logic [4:0]        month_bcd;
	logic [7:0]        year_bcd;

	time_req_t pending_times[$];   // times waiting to be offered
	rtc_regs_t due_regs[$];        // register bytes owed by the block, oldest first
	time_req_t offered;            // payload currently on the input port

	int accepted_cnt = 0;
	int results_cnt = 0;
	int mismatch_cnt = 0;
	int hold_left = 0;
	bit hold_used = 1'b0;
	int input_stalls = 0;
	bit calm;

	assign calm = (accepted_cnt >= CalmFrom) && (accepted_cnt < CalmTo);

	rtc_time_register_encoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sec_in   (sec_in),
		.min_in   (min_in),
		.hour_in  (hour_in),
		.date_in  (date_in),
		.month_in (month_in),
		.year_in  (year_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sec_bcd  (sec_bcd),
		.min_bcd  (min_bcd),
		.hour_bcd (hour_bcd),
		.weekday  (weekday),
		.date_bcd (date_bcd),
		.month_bcd(month_bcd),
		.year_bcd (year_bcd)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// encoder model
	// ---------------------------------------------------------------

	// february is always 28 days here, leap or not
	function automatic int days_of_month(input int m);
		int len;
		case (m)
			2:             len = 28;
			4, 6, 9, 11:   len = 30;
			default:       len = 31;
		endcase
		return len;
	endfunction

	function automatic int clamp_to(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// tens in the high nibble, ones in the low nibble
	function automatic logic [7:0] packed_bcd(input int v);
		return 8'((((v / 10) % 10) << 4) | (v % 10));
	endfunction

	function automatic rtc_regs_t encode_time(input time_req_t t);
		rtc_regs_t r;
		int s, mi, h, mo, d, yoff, days;
		s = clamp_to(int'(t.sec), 0, 59);
		mi = clamp_to(int'(t.min), 0, 59);
		h = clamp_to(int'(t.hour), 0, 23);
		mo = clamp_to(int'(t.month), 1, 12);
		d = clamp_to(int'(t.date), 0, days_of_month(mo));
		yoff = clamp_to(int'(t.year), 2000, 2099) - 2000;
		// days into the year, with the extra day once past february of a leap year
		days = d;
		for (int k = 1; k < mo; k++)
			days += days_of_month(k);
		if (mo > 2 && (yoff % 4) == 0)
			days++;
		// day count since the start of 2000 plus the offset of that year, 1 = monday
		r.weekday = 3'(((days + 365 * yoff + (yoff + 3) / 4 + 4) % 7) + 1);
		r.sec_bcd = 7'(packed_bcd(s));
		r.min_bcd = 7'(packed_bcd(mi));
		r.hour_bcd = 6'(packed_bcd(h));
		r.date_bcd = 6'(packed_bcd(d));
		r.month_bcd = 5'(packed_bcd(mo));
		r.year_bcd = packed_bcd(yoff);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	function automatic time_req_t time_of(input int s, input int mi, input int h, input int d,
		input int mo, input int y);
		time_req_t t;
		t.sec = 8'(s);
		t.min = 8'(mi);
		t.hour = 8'(h);
		t.date = 8'(d);
		t.month = 8'(mo);
		t.year = 12'(y);
		return t;
	endfunction

	// mostly plausible calendar times, each field now and then a raw random value
	function automatic time_req_t random_time();
		time_req_t t;
		int mo;
		t.sec = ($urandom_range(99) < 15) ? 8'($urandom) : 8'($urandom_range(59));
		t.min = ($urandom_range(99) < 15) ? 8'($urandom) : 8'($urandom_range(59));
		t.hour = ($urandom_range(99) < 15) ? 8'($urandom) : 8'($urandom_range(23));
		mo = ($urandom_range(99) < 15) ? int'($urandom_range(255)) : int'($urandom_range(1, 12));
		t.month = 8'(mo);
		if ($urandom_range(99) < 15)
			t.date = 8'($urandom);
		else if (mo >= 1 && mo <= 12 && $urandom_range(99) < 70)
			t.date = 8'($urandom_range(1, days_of_month(mo)));
		else
			t.date = 8'($urandom_range(0, 31));
		t.year = ($urandom_range(99) < 15) ? 12'($urandom) : 12'($urandom_range(2000, 2099));
		return t;
	endfunction

	// ---------------------------------------------------------------
	// driver: takes times from the pending queue, idles at random
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		bit gap;
		time_req_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				due_regs.push_back(encode_time(offered));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (in_valid && !in_ready)
				input_stalls <= input_stalls + 1;
			// a new beat only goes out once the previous one is taken
			if (!in_valid || in_ready) begin
				gap = !calm && ($urandom_range(99) < 29);
				if (!gap && pending_times.size() > 0) begin
					nxt = pending_times.pop_front();
					offered <= nxt;
					in_valid <= 1'b1;
					sec_in <= nxt.sec;
					min_in <= nxt.min;
					hour_in <= nxt.hour;
					date_in <= nxt.date;
					month_in <= nxt.month;
					year_in <= nxt.year;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: random back pressure plus one long hold that fills the pipe
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_used && results_cnt >= HoldAtResult) begin
				hold_used <= 1'b1;
				hold_left <= HoldCycles;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 29);
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: every result beat against the oldest owed register set
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		rtc_regs_t got;
		rtc_regs_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{sec_bcd, min_bcd, hour_bcd, weekday, date_bcd, month_bcd, year_bcd};
			results_cnt <= results_cnt + 1;
			if (due_regs.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: result beat with nothing owed: %h %h %h %h %h %h %h", $realtime,
						got.sec_bcd, got.min_bcd, got.hour_bcd, got.weekday,
						got.date_bcd, got.month_bcd, got.year_bcd);
			end else begin
				want = due_regs.pop_front();
				if (got.sec_bcd !== want.sec_bcd || got.min_bcd !== want.min_bcd ||
					got.hour_bcd !== want.hour_bcd || got.weekday !== want.weekday ||
					got.date_bcd !== want.date_bcd || got.month_bcd !== want.month_bcd ||
					got.year_bcd !== want.year_bcd) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) begin
						$display("%0t: mismatch on result %0d", $realtime, results_cnt);
						$display("  sec/min/hour/wday/date/month/year expected %h %h %h %h %h %h %h",
							want.sec_bcd, want.min_bcd, want.hour_bcd, want.weekday,
							want.date_bcd, want.month_bcd, want.year_bcd);
						$display("  sec/min/hour/wday/date/month/year actual   %h %h %h %h %h %h %h",
							got.sec_bcd, got.min_bcd, got.hour_bcd, got.weekday,
							got.date_bcd, got.month_bcd, got.year_bcd);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// sequence: reset, directed corners, a full drain, then random beats
	// ---------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// whole-range corners of every field
		pending_times.push_back(time_of(-128, -128, -128, -128, -128, 0));
		pending_times.push_back(time_of(127, 127, 127, 127, 127, 4095));
		pending_times.push_back(time_of(0, 0, 0, 0, 0, 0));
		pending_times.push_back(time_of(-1, -1, -1, -1, -1, 1999));
		// clamp edges of seconds, minutes and hours
		pending_times.push_back(time_of(59, 59, 23, 15, 6, 2050));
		pending_times.push_back(time_of(60, 60, 24, 15, 6, 2051));
		// year saturation at both ends
		pending_times.push_back(time_of(1, 2, 3, 1, 1, 2000));
		pending_times.push_back(time_of(1, 2, 3, 31, 12, 2099));
		pending_times.push_back(time_of(1, 2, 3, 31, 12, 2100));
		// month clamp below and above
		pending_times.push_back(time_of(30, 30, 12, 10, 13, 2023));
		pending_times.push_back(time_of(30, 30, 12, 10, 0, 2023));
		// leap february: the 29th is held at 28
		pending_times.push_back(time_of(0, 0, 0, 29, 2, 2024));
		pending_times.push_back(time_of(0, 0, 0, 28, 2, 2024));
		pending_times.push_back(time_of(0, 0, 0, 31, 2, 2023));
		// leap correction just after february, leap and common year
		pending_times.push_back(time_of(0, 0, 0, 1, 3, 2000));
		pending_times.push_back(time_of(0, 0, 0, 1, 3, 2001));
		// date zero takes the weekday of the last day before
		pending_times.push_back(time_of(0, 0, 0, 0, 3, 2024));
		pending_times.push_back(time_of(0, 0, 0, 0, 1, 2000));
		// thirty-day month clamps the 31st
		pending_times.push_back(time_of(45, 45, 20, 31, 4, 2077));
		pending_times.push_back(time_of(45, 45, 20, 30, 11, 2096));
		pending_times.push_back(time_of(9, 19, 9, 9, 9, 2009));

		// sender pause: nothing new until every owed result is back
		do @(negedge clk);
		while (pending_times.size() > 0 || in_valid || due_regs.size() > 0);

		for (int k = 0; k < RandomBeats; k++)
			pending_times.push_back(random_time());

		do @(negedge clk);
		while (pending_times.size() > 0 || in_valid || due_regs.size() > 0);
		repeat (DrainCycles) @(posedge clk);

		if (due_regs.size() > 0)
			mismatch_cnt += due_regs.size();

		$display("covered %0d time beats (corners, clamps, leap and date-zero cases, random times)",
			accepted_cnt);
		$display("%0d result beats, %0d cycles with the input held off, %0d mismatches",
			results_cnt, input_stalls, mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("rtc_time_register_encoder_top verification clean");
		else
			$display("rtc_time_register_encoder_top verification failed");
		$finish;
	end

	// hard stop well beyond any correct run
	initial begin
		#2ms;
		$display("timeout after %0d results", results_cnt);
		$display("rtc_time_register_encoder_top verification failed");
		$finish;
	end

endmodule

### rtc_time_register_encoder_top.f
rtl/rtc_enc_pkg.sv
rtl/rtc_time_register_encoder_top.sv
rtl/rtc_enc_checker.sv
sim/tb_rtc_time_register_encoder_top.sv
